// ----- sv/cscm_pkg.sv -----
// ----------------------------------------------------------------------------
// cscm_pkg: shared types and constants for the C# comment/string masker
// Queue entry, push bundle and queue status types, byte codes, defaults.
// ----------------------------------------------------------------------------
package cscm_pkg;

  // Default depth of the result queue between front and back (power of two, >= 2)
  localparam int QDEPTH_DEFAULT = 4;

  // Byte codes
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_AT     = 8'h40;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;

  // One result byte
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } entry_t;

  // Up to two result bytes written into the queue in one cycle
  typedef struct packed {
    logic [1:0] count;  // 0, 1 or 2 entries
    entry_t     e0;     // first in order
    entry_t     e1;     // second in order
  } push_t;

  // Queue status toward front and back
  typedef struct packed {
    logic room2;     // space for two more entries
    logic nonempty;  // head entry is valid
  } qstat_t;

endpackage

// ----- sv/cscm_in_if.sv -----
// ----------------------------------------------------------------------------
// cscm_in_if: raw source byte channel
// valid/ready handshake carrying one source byte and its last marker.
// ----------------------------------------------------------------------------
interface cscm_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

// ----- sv/cscm_out_if.sv -----
// ----------------------------------------------------------------------------
// cscm_out_if: masked byte channel
// valid/ready handshake carrying one masked byte and its last marker.
// ----------------------------------------------------------------------------
interface cscm_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_last;

  modport source (output valid, output out_byte, output out_last, input ready);
  modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

// ----- sv/cscm_front.sv -----
// ----------------------------------------------------------------------------
// cscm_front: lexer front end
// Accepts source bytes, holds one byte for lookahead, classifies it and
// pushes zero, one or two masked bytes into the result queue.
// ----------------------------------------------------------------------------
module cscm_front (
  input  logic               clk,
  input  logic               rst,
  cscm_in_if.sink            text,
  input  cscm_pkg::qstat_t   qstat,
  output cscm_pkg::push_t    push
);

  typedef enum logic [5:0] {
    MODE_CODE     = 6'b000001,
    MODE_LINE     = 6'b000010,
    MODE_BLOCK    = 6'b000100,
    MODE_STRING   = 6'b001000,
    MODE_VERBATIM = 6'b010000,
    MODE_CHAR     = 6'b100000
  } mode_t;

  typedef struct packed {
    logic [7:0] m0;
    logic [7:0] m1;
    logic       pair;
    mode_t      mode;
    logic       esc;
  } judge_t;

  function automatic logic [7:0] blank(input logic [7:0] c);
    return (c == cscm_pkg::CH_LF || c == cscm_pkg::CH_CR) ? c : cscm_pkg::CH_SPACE;
  endfunction

  // Judge byte c against the current lexer state, with optional lookahead nx
  function automatic judge_t judge(input mode_t mode, input logic esc,
                                   input logic [7:0] c, input logic have_nx,
                                   input logic [7:0] nx);
    judge_t j;
    j.m0   = c;
    j.m1   = nx;
    j.pair = 1'b0;
    j.mode = mode;
    j.esc  = esc;
    unique case (mode)
      MODE_LINE: begin
        if (c == cscm_pkg::CH_LF) j.mode = MODE_CODE;
        else j.m0 = blank(c);
      end
      MODE_BLOCK: begin
        j.m0 = blank(c);
        if (c == cscm_pkg::CH_STAR && have_nx && nx == cscm_pkg::CH_SLASH) begin
          j.m1   = cscm_pkg::CH_SPACE;
          j.mode = MODE_CODE;
          j.pair = 1'b1;
        end
      end
      MODE_VERBATIM: begin
        j.m0 = blank(c);
        if (c == cscm_pkg::CH_DQUOTE) begin
          if (have_nx && nx == cscm_pkg::CH_DQUOTE) begin
            j.m1   = cscm_pkg::CH_SPACE;
            j.pair = 1'b1;
          end else begin
            j.mode = MODE_CODE;
          end
        end
      end
      MODE_STRING, MODE_CHAR: begin
        j.m0 = blank(c);
        if (esc) begin
          j.esc = 1'b0;
        end else if (c == cscm_pkg::CH_BSLASH) begin
          j.esc = 1'b1;
        end else if ((mode == MODE_STRING && c == cscm_pkg::CH_DQUOTE) ||
                     (mode == MODE_CHAR && c == cscm_pkg::CH_SQUOTE)) begin
          j.mode = MODE_CODE;
        end
      end
      default: begin
        // plain code (unused codes behave the same)
        if (have_nx && ((c == cscm_pkg::CH_SLASH &&
                         (nx == cscm_pkg::CH_SLASH || nx == cscm_pkg::CH_STAR)) ||
                        (c == cscm_pkg::CH_AT && nx == cscm_pkg::CH_DQUOTE))) begin
          j.mode = (c == cscm_pkg::CH_AT)    ? MODE_VERBATIM :
                   (nx == cscm_pkg::CH_SLASH) ? MODE_LINE : MODE_BLOCK;
          j.m0   = cscm_pkg::CH_SPACE;
          j.m1   = cscm_pkg::CH_SPACE;
          j.pair = 1'b1;
        end else if (c == cscm_pkg::CH_DQUOTE || c == cscm_pkg::CH_SQUOTE) begin
          j.mode = (c == cscm_pkg::CH_DQUOTE) ? MODE_STRING : MODE_CHAR;
          j.m0   = cscm_pkg::CH_SPACE;
        end
      end
    endcase
    return j;
  endfunction

  mode_t      mode, mode_next;
  logic       esc, esc_next;
  logic [7:0] held_byte;
  logic       held_valid, held_valid_next;
  logic       accept;
  judge_t     j_held, j_new;
  mode_t      mode_mid;
  logic       esc_mid;

  assign text.ready = qstat.room2;
  assign accept     = text.valid && text.ready;

  always_comb begin
    // held byte judged with the new byte as lookahead
    j_held   = judge(mode, esc, held_byte, 1'b1, text.in_byte);
    mode_mid = held_valid ? j_held.mode : mode;
    esc_mid  = held_valid ? j_held.esc  : esc;
    // final byte judged with no lookahead
    j_new    = judge(mode_mid, esc_mid, text.in_byte, 1'b0, 8'h00);

    push.e0.data = held_valid ? j_held.m0 : j_new.m0;
    push.e0.last = !held_valid;
    push.e1.data = j_held.pair ? j_held.m1 : j_new.m0;
    push.e1.last = j_held.pair ? text.in_last : 1'b1;

    push.count      = 2'd0;
    mode_next       = mode;
    esc_next        = esc;
    held_valid_next = held_valid;
    if (accept) begin
      if (held_valid && j_held.pair) begin
        push.count      = 2'd2;
        mode_next       = j_held.mode;
        esc_next        = j_held.esc;
        held_valid_next = 1'b0;
      end else if (text.in_last) begin
        push.count      = held_valid ? 2'd2 : 2'd1;
        mode_next       = j_new.mode;
        esc_next        = j_new.esc;
        held_valid_next = 1'b0;
      end else begin
        push.count      = held_valid ? 2'd1 : 2'd0;
        mode_next       = mode_mid;
        esc_next        = esc_mid;
        held_valid_next = 1'b1;
      end
      if (text.in_last) begin
        mode_next = MODE_CODE;
        esc_next  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= MODE_CODE;
      esc        <= 1'b0;
      held_valid <= 1'b0;
    end else begin
      mode       <= mode_next;
      esc        <= esc_next;
      held_valid <= held_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) held_byte <= text.in_byte;
  end

endmodule

// ----- sv/cscm_queue.sv -----
// ----------------------------------------------------------------------------
// cscm_queue: result queue between front and back
// Takes up to two entries per cycle, gives one per cycle from the head when popped.
// ----------------------------------------------------------------------------
module cscm_queue #(
  parameter int DEPTH = cscm_pkg::QDEPTH_DEFAULT  // power of two, >= 2
) (
  input  logic              clk,
  input  logic              rst,
  input  cscm_pkg::push_t   push,
  input  logic              pop,
  output cscm_pkg::entry_t  head,
  output cscm_pkg::qstat_t  qstat
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  cscm_pkg::entry_t entries [DEPTH];
  logic [PTR_W-1:0] wptr, rptr;
  logic [CNT_W-1:0] count;

  assign head           = entries[rptr];
  assign qstat.nonempty = (count != '0);
  assign qstat.room2    = (count <= CNT_W'(DEPTH - 2));

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      wptr  <= wptr + PTR_W'(push.count);
      rptr  <= rptr + PTR_W'(pop);
      count <= count + CNT_W'(push.count) - CNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) entries[wptr] <= push.e0;
    if (push.count == 2'd2) entries[PTR_W'(wptr + 1'b1)] <= push.e1;
  end

endmodule

// ----- sv/cscm_back.sv -----
// ----------------------------------------------------------------------------
// cscm_back: output stage
// Moves the queue head into the output register whenever it is free.
// ----------------------------------------------------------------------------
module cscm_back (
  input  logic              clk,
  input  logic              rst,
  input  cscm_pkg::entry_t  head,
  input  cscm_pkg::qstat_t  qstat,
  output logic              pop,
  cscm_out_if.source        masked
);

  logic       valid;
  logic [7:0] data;
  logic       last;

  assign pop             = qstat.nonempty && (!valid || masked.ready);
  assign masked.valid    = valid;
  assign masked.out_byte = data;
  assign masked.out_last = last;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (pop) begin
      valid <= 1'b1;
    end else if (masked.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      data <= head.data;
      last <= head.last;
    end
  end

endmodule

// ----- sv/csharp_comment_string_masker.sv -----
// ----------------------------------------------------------------------------
// csharp_comment_string_masker: blanks C# comments and literals in a stream
// Source bytes in, same bytes out with comments, strings, verbatim strings
// and character literals (marks included) turned into spaces; CR/LF kept.
//
// Usage:
//   text   : sink channel, one source byte per transaction, in_last on the
//            final byte of a text.
//   masked : source channel, one masked byte per transaction, out_last on
//            the final byte of the text.
//   Each byte is held back until the next one arrives (one byte of
//   lookahead), so a transaction may produce zero, one or two output bytes;
//   the final byte of a text is flushed at once.
//   Throughput: one input transaction per cycle while the queue has room
//   for two entries. The front end takes a byte whenever the queue has
//   room for two entries; the output register drains one byte per cycle
//   while the receiver is ready. Timing: a released byte is written into
//   the queue at the accepting edge and is loaded from the queue head into
//   the output register once that register is free; the second byte of a
//   pair follows the first through the queue and the output register.
//   Reset (rst, synchronous): lexer back in code mode, hold and queue empty.
//   A stalled receiver keeps the output byte in place; the queue
//   (QDEPTH entries) fills, and text.ready drops as soon as fewer than two
//   entries are free.
// ----------------------------------------------------------------------------
module csharp_comment_string_masker #(
  parameter int QDEPTH = cscm_pkg::QDEPTH_DEFAULT  // power of two, >= 2
) (
  input  logic        clk,
  input  logic        rst,
  cscm_in_if.sink     text,
  cscm_out_if.source  masked
);

  cscm_pkg::push_t  push;   // front -> queue
  cscm_pkg::qstat_t qstat;  // queue -> front and back
  cscm_pkg::entry_t head;   // queue head -> back
  logic             pop;    // back takes the head

  // Front: handshake, lookahead hold, lexer state, masking
  cscm_front u_front (
    .clk   (clk),
    .rst   (rst),
    .text  (text),
    .qstat (qstat),
    .push  (push)
  );

  // Queue: absorbs the two-byte bursts
  cscm_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .pop   (pop),
    .head  (head),
    .qstat (qstat)
  );

  // Back: output register
  cscm_back u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (head),
    .qstat  (qstat),
    .pop    (pop),
    .masked (masked)
  );

  // Front only writes when there is room for a full burst
  a_push_room: assert property (@(posedge clk) disable iff (rst)
    (push.count != 2'd0) |-> qstat.room2)
    else $error("queue write without room");

  // Back never takes from an empty queue
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> qstat.nonempty)
    else $error("pop from empty queue");

  // A final byte always leaves something queued
  a_last_flush: assert property (@(posedge clk) disable iff (rst)
    (text.valid && text.ready && text.in_last) |=> qstat.nonempty)
    else $error("final byte not flushed");

  // The front never writes a burst bigger than two, and writes only while text.valid is high
  a_push_count: assert property (@(posedge clk) disable iff (rst)
    (push.count != 2'd3) && ((push.count == 2'd0) || text.valid))
    else $error("bad push count");

endmodule
